// ===== rtl/vcdv_pkg.sv =====
// vcdv_pkg: shared types, constants and table functions for the VIN check-digit validator.
// Used by vcdv_char_map, vcdv_accum and vin_check_digit_validator; no dependencies.
package vcdv_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned VALUE_W   = 4;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned RES_W     = 4;

    localparam logic [POS_W-1:0]  VIN_LEN     = POS_W'(17);
    localparam logic [POS_W-1:0]  CHECK_POS   = POS_W'(8);
    localparam logic [RES_W-1:0]  CHECK_TEN   = RES_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_X      = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ     = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // x / 11 for x <= 100 as (x * 187) >> 11
    localparam logic [7:0] MOD11_RECIP = 8'd187;
    localparam int unsigned MOD11_SHIFT = 11;
    localparam logic [6:0] MODULUS = 7'd11;

    typedef struct packed {
        logic [CHAR_W-1:0]  upper;
        logic [VALUE_W-1:0] value;
        logic               ok;
    } t_char_info;

    typedef struct packed {
        logic               check_ok;
        logic [RES_W-1:0]   expected_check;
        logic               length_error;
        logic               bad_character;
    } t_result;

    // transliteration of A..Z by letter index; ok is low for I, O and Q
    function automatic logic [VALUE_W:0] letter_value(input logic [4:0] k);
        logic [VALUE_W:0] v;
        begin
            case (k)
                5'd0:  v = {1'b1, 4'd1};
                5'd1:  v = {1'b1, 4'd2};
                5'd2:  v = {1'b1, 4'd3};
                5'd3:  v = {1'b1, 4'd4};
                5'd4:  v = {1'b1, 4'd5};
                5'd5:  v = {1'b1, 4'd6};
                5'd6:  v = {1'b1, 4'd7};
                5'd7:  v = {1'b1, 4'd8};
                5'd8:  v = {1'b0, 4'd0};
                5'd9:  v = {1'b1, 4'd1};
                5'd10: v = {1'b1, 4'd2};
                5'd11: v = {1'b1, 4'd3};
                5'd12: v = {1'b1, 4'd4};
                5'd13: v = {1'b1, 4'd5};
                5'd14: v = {1'b0, 4'd0};
                5'd15: v = {1'b1, 4'd7};
                5'd16: v = {1'b0, 4'd0};
                5'd17: v = {1'b1, 4'd9};
                5'd18: v = {1'b1, 4'd2};
                5'd19: v = {1'b1, 4'd3};
                5'd20: v = {1'b1, 4'd4};
                5'd21: v = {1'b1, 4'd5};
                5'd22: v = {1'b1, 4'd6};
                5'd23: v = {1'b1, 4'd7};
                5'd24: v = {1'b1, 4'd8};
                5'd25: v = {1'b1, 4'd9};
                default: v = {1'b0, 4'd0};
            endcase
            return v;
        end
    endfunction

    function automatic logic [3:0] pos_weight(input logic [POS_W-1:0] pos);
        logic [3:0] w;
        begin
            case (pos)
                5'd0:  w = 4'd8;
                5'd1:  w = 4'd7;
                5'd2:  w = 4'd6;
                5'd3:  w = 4'd5;
                5'd4:  w = 4'd4;
                5'd5:  w = 4'd3;
                5'd6:  w = 4'd2;
                5'd7:  w = 4'd10;
                5'd9:  w = 4'd9;
                5'd10: w = 4'd8;
                5'd11: w = 4'd7;
                5'd12: w = 4'd6;
                5'd13: w = 4'd5;
                5'd14: w = 4'd4;
                5'd15: w = 4'd3;
                5'd16: w = 4'd2;
                default: w = 4'd0;
            endcase
            return w;
        end
    endfunction

    // remainder by 11 for x in 0..100
    function automatic logic [RES_W-1:0] mod11(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        begin
            prod = 15'(x) * 15'(MOD11_RECIP);
            q    = prod[14:MOD11_SHIFT];
            r    = x - 7'(q * MODULUS);
            return r[RES_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/vcdv_char_map.sv =====
// vcdv_char_map: upper-cases one ASCII byte and maps it to its VIN value.
// Depends on vcdv_pkg.
module vcdv_char_map (
    input  logic [vcdv_pkg::CHAR_W-1:0] i_char,
    output vcdv_pkg::t_char_info        o_info
);

    logic [vcdv_pkg::CHAR_W-1:0]  upper;
    logic [vcdv_pkg::CHAR_W-1:0]  letter_idx;
    logic [vcdv_pkg::VALUE_W:0]   letter;

    always_comb begin
        if (i_char >= vcdv_pkg::CHAR_LA && i_char <= vcdv_pkg::CHAR_LZ) begin
            upper = i_char - vcdv_pkg::CASE_OFFSET;
        end else begin
            upper = i_char;
        end
        letter_idx = upper - vcdv_pkg::CHAR_UA;
        letter     = vcdv_pkg::letter_value(letter_idx[4:0]);

        o_info.upper = upper;
        if (upper >= vcdv_pkg::CHAR_ZERO && upper <= vcdv_pkg::CHAR_NINE) begin
            o_info.value = letter_idx[3:0] + 4'(vcdv_pkg::CHAR_UA - vcdv_pkg::CHAR_ZERO);
            o_info.ok    = 1'b1;
        end else if (upper >= vcdv_pkg::CHAR_UA && upper <= vcdv_pkg::CHAR_UZ) begin
            o_info.value = letter[vcdv_pkg::VALUE_W-1:0];
            o_info.ok    = letter[vcdv_pkg::VALUE_W];
        end else begin
            o_info.value = '0;
            o_info.ok    = 1'b0;
        end
    end

endmodule

// ===== rtl/vcdv_accum.sv =====
// vcdv_accum: per-VIN running state (position, mod-11 residue, check char, flags)
// and the result word built on the last character. Depends on vcdv_pkg.
module vcdv_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_last,
    input  vcdv_pkg::t_char_info  i_info,
    output vcdv_pkg::t_result     o_result
);

    logic [vcdv_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic [vcdv_pkg::RES_W-1:0]  r_sum,   n_sum;
    logic [vcdv_pkg::CHAR_W-1:0] r_given, n_given;
    logic                        r_bad,   n_bad;
    logic                        r_long,  n_long;

    logic [7:0]                  term;
    logic [vcdv_pkg::CHAR_W-1:0] exp_char;
    logic                        len_err;

    // step of the model with the current character
    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_given = r_given;
        n_bad   = r_bad | ~i_info.ok;
        n_long  = r_long;
        term    = i_info.value * vcdv_pkg::pos_weight(r_pos);
        if (r_pos < vcdv_pkg::VIN_LEN) begin
            if (r_pos == vcdv_pkg::CHECK_POS) begin
                n_given = i_info.upper;
            end else begin
                n_sum = vcdv_pkg::mod11(7'(term) + 7'(r_sum));
            end
            n_pos = r_pos + 1'b1;
        end else begin
            n_long = 1'b1;
        end
    end

    always_comb begin
        if (n_sum == vcdv_pkg::CHECK_TEN) begin
            exp_char = vcdv_pkg::CHAR_X;
        end else begin
            exp_char = vcdv_pkg::CHAR_ZERO + 8'(n_sum);
        end
        len_err                 = n_long | (n_pos != vcdv_pkg::VIN_LEN);
        o_result.check_ok       = ~len_err & ~n_bad & (n_given == exp_char);
        o_result.expected_check = n_sum;
        o_result.length_error   = len_err;
        o_result.bad_character  = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_given <= '0;
            r_bad   <= 1'b0;
            r_long  <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_pos   <= '0;
                r_sum   <= '0;
                r_given <= '0;
                r_bad   <= 1'b0;
                r_long  <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_given <= n_given;
                r_bad   <= n_bad;
                r_long  <= n_long;
            end
        end
    end

endmodule

// ===== rtl/vin_check_digit_validator.sv =====
// vin_check_digit_validator: top level with input register, character map,
// accumulator and result register. Depends on vcdv_pkg, vcdv_char_map, vcdv_accum.
//
// Takes a VIN one character beat per cycle and, on the beat flagged last, returns one
// result beat: expected mod-11 check value (10 stands for X), length and character
// error flags, and an overall check_ok. Sustained rate is one character per cycle,
// set by the combinational residue update (weight multiply plus mod-11 reduction)
// between the input register and the state registers; a result is loaded into the result
// register as its last character leaves the input register. The result register
// holds a result while the downstream side stalls; only a further last beat waits
// for it to drain, ordinary characters keep flowing.
module vin_check_digit_validator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vcdv_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_last_char,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_check_ok,
    output logic [vcdv_pkg::RES_W-1:0]  o_expected_check,
    output logic                        o_length_error,
    output logic                        o_bad_character
);

    logic                        r_in_valid, n_in_valid;
    logic [vcdv_pkg::CHAR_W-1:0] r_char;
    logic                        r_last;
    logic                        r_out_valid, n_out_valid;
    vcdv_pkg::t_result           r_result;

    vcdv_pkg::t_char_info        info;
    vcdv_pkg::t_result           result;
    logic                        fire;
    logic                        load_out;

    // a last beat needs a free result slot, other beats always advance
    assign fire     = r_in_valid & (~r_last | ~r_out_valid | i_ready);
    assign load_out = fire & r_last;
    assign o_ready  = ~r_in_valid | fire;

    assign n_in_valid  = (i_valid & o_ready) | (r_in_valid & ~fire);
    assign n_out_valid = load_out | (r_out_valid & ~i_ready);

    vcdv_char_map u_char_map (
        .i_char (r_char),
        .o_info (info)
    );

    vcdv_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_last   (r_last),
        .i_info   (info),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
            r_last <= i_last_char;
        end
        if (load_out) begin
            r_result <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_check_ok       = r_result.check_ok;
    assign o_expected_check = r_result.expected_check;
    assign o_length_error   = r_result.length_error;
    assign o_bad_character  = r_result.bad_character;

    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_check_ok && (o_length_error || o_bad_character)))
        else $error("check_ok set together with an error flag");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_expected_check <= vcdv_pkg::CHECK_TEN))
        else $error("expected_check out of range");

    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_ready) |-> (r_last && r_out_valid))
        else $error("input stalled on a beat that should advance");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("held result changed");

endmodule

// ===== bench/vin_check_digit_validator_tb.sv =====
// vin_check_digit_validator_tb: self-checking bench for the VIN check-digit validator.
// Needs vcdv_pkg and the vin_check_digit_validator RTL. A tracker class predicts each
// result from the accepted character beats and checks the result beats against it.
module vin_check_digit_validator_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TARGET_CHARS = 550;
    localparam int SETTLE_CYCLES = 8;

    localparam int POS_WEIGHT[17] = '{8, 7, 6, 5, 4, 3, 2, 10, 0, 9, 8, 7, 6, 5, 4, 3, 2};
    localparam int TRANSLIT[26] = '{1, 2, 3, 4, 5, 6, 7, 8, 0, 1, 2, 3, 4,
                                    5, 0, 7, 0, 9, 2, 3, 4, 5, 6, 7, 8, 9};
    localparam string LEGAL_CHARS = "0123456789ABCDEFGHJKLMNPRSTUVWXYZ";
    localparam string BAD_LETTERS = "IOQioq";

    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_style;
    typedef enum {VIN_GOOD, VIN_WRONG_CHECK, VIN_BAD_CHAR, VIN_SHORT, VIN_LONG,
                  VIN_NOISE} t_vin_kind;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [vcdv_pkg::CHAR_W-1:0]   i_char_code;
    logic                          i_last_char;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_check_ok;
    logic [vcdv_pkg::RES_W-1:0]    o_expected_check;
    logic                          o_length_error;
    logic                          o_bad_character;

    vin_check_digit_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_check_ok      (o_check_ok),
        .o_expected_check(o_expected_check),
        .o_length_error  (o_length_error),
        .o_bad_character (o_bad_character)
    );

    function automatic logic [7:0] upcase(input logic [7:0] code);
        if (code >= "a" && code <= "z") begin
            return code - 8'h20;
        end
        return code;
    endfunction

    // {ok, value} of one character after upper-casing
    function automatic logic [4:0] char_value(input logic [7:0] code);
        logic [7:0] u;
        int         k;
        u = upcase(code);
        if (u >= "0" && u <= "9") begin
            return {1'b1, 4'(u - "0")};
        end
        if (u >= "A" && u <= "Z") begin
            k = u - "A";
            if (u == "I" || u == "O" || u == "Q") begin
                return 5'd0;
            end
            return {1'b1, 4'(TRANSLIT[k])};
        end
        return 5'd0;
    endfunction

    class t_vin_check_tracker;
        logic [vcdv_pkg::POS_W-1:0]  char_pos;
        logic [vcdv_pkg::RES_W-1:0]  residue;
        logic [vcdv_pkg::CHAR_W-1:0] check_char;
        bit                          bad_seen;
        bit                          too_long;
        vcdv_pkg::t_result           verdict_q[$];
        int unsigned                 mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            char_pos   = '0;
            residue    = '0;
            check_char = '0;
            bad_seen   = 1'b0;
            too_long   = 1'b0;
        endfunction

        function void note_char(input logic [7:0] code, input logic last);
            logic [4:0]                  cv;
            logic [vcdv_pkg::CHAR_W-1:0] want_char;
            vcdv_pkg::t_result           r;
            cv = char_value(code);
            if (!cv[4]) begin
                bad_seen = 1'b1;
            end
            if (char_pos < vcdv_pkg::VIN_LEN) begin
                if (char_pos == vcdv_pkg::CHECK_POS) begin
                    check_char = upcase(code);
                end else begin
                    residue = vcdv_pkg::RES_W'((int'(residue)
                              + int'(cv[3:0]) * POS_WEIGHT[char_pos]) % 11);
                end
                char_pos++;
            end else begin
                too_long = 1'b1;
            end
            if (last) begin
                want_char        = (residue == vcdv_pkg::CHECK_TEN) ? vcdv_pkg::CHAR_X :
                                   vcdv_pkg::CHAR_ZERO + vcdv_pkg::CHAR_W'(residue);
                r.length_error   = too_long || char_pos != vcdv_pkg::VIN_LEN;
                r.bad_character  = bad_seen;
                r.expected_check = residue;
                r.check_ok       = !r.length_error && !bad_seen && check_char == want_char;
                verdict_q.push_back(r);
                restart();
            end
        endfunction

        function void check_verdict(input vcdv_pkg::t_result got);
            vcdv_pkg::t_result want;
            if (verdict_q.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.check_ok !== want.check_ok) begin
                $error("check_ok: expected %0d, got %0d", want.check_ok, got.check_ok);
                mismatches++;
            end
            if (got.expected_check !== want.expected_check) begin
                $error("expected_check: expected %0d, got %0d",
                       want.expected_check, got.expected_check);
                mismatches++;
            end
            if (got.length_error !== want.length_error) begin
                $error("length_error: expected %0d, got %0d",
                       want.length_error, got.length_error);
                mismatches++;
            end
            if (got.bad_character !== want.bad_character) begin
                $error("bad_character: expected %0d, got %0d",
                       want.bad_character, got.bad_character);
                mismatches++;
            end
        endfunction
    endclass

    t_vin_check_tracker tracker;
    int unsigned        idle_cycles;
    int unsigned        chars_sent;
    int unsigned        burst_left;
    t_rx_style          rx_style;
    int unsigned        rx_left;
    int unsigned        rx_tick;

    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // receiver: check result beats, stall on a pattern of its own, count idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_verdict({o_check_ok, o_expected_check, o_length_error,
                                   o_bad_character});
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 3));
            rx_left  <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_style)
            RX_OPEN:     i_ready <= 1'b1;
            RX_MOSTLY:   i_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_ready <= ((rx_tick % 7) < 2);
            default:     i_ready <= 1'b1;
        endcase
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_char(input logic [7:0] code, input logic last);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_char_code <= code;
        i_last_char <= last;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        tracker.note_char(code, last);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            // new burst; a zero gap makes long stretches with no idling
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_vin(input logic [7:0] chars[$]);
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_legal();
        logic [7:0] c;
        c = LEGAL_CHARS[$urandom_range(0, LEGAL_CHARS.len() - 1)];
        if (c >= "A" && $urandom_range(0, 1)) begin
            c = c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_bad();
        logic [7:0] c;
        logic [4:0] cv;
        if ($urandom_range(0, 1)) begin
            return BAD_LETTERS[$urandom_range(0, BAD_LETTERS.len() - 1)];
        end
        do begin
            c  = 8'($urandom_range(0, 255));
            cv = char_value(c);
        end while (cv[4]);
        return c;
    endfunction

    // fill the check place of a 17-character vin with the matching character
    function automatic void seal_vin(ref logic [7:0] chars[$]);
        int         sum;
        logic [4:0] cv;
        sum = 0;
        for (int p = 0; p < 17; p++) begin
            if (p != vcdv_pkg::CHECK_POS) begin
                cv  = char_value(chars[p]);
                sum = (sum + int'(cv[3:0]) * POS_WEIGHT[p]) % 11;
            end
        end
        if (sum == 10) begin
            chars[vcdv_pkg::CHECK_POS] = $urandom_range(0, 1) ? vcdv_pkg::CHAR_X : "x";
        end else begin
            chars[vcdv_pkg::CHECK_POS] = vcdv_pkg::CHAR_ZERO + 8'(sum);
        end
    endfunction

    task automatic send_random_vin();
        logic [7:0] chars[$];
        t_vin_kind  kind;
        int         pick;
        int         len;
        pick = $urandom_range(0, 99);
        kind = (pick < 50) ? VIN_GOOD :
               (pick < 64) ? VIN_WRONG_CHECK :
               (pick < 76) ? VIN_BAD_CHAR :
               (pick < 86) ? VIN_SHORT :
               (pick < 95) ? VIN_LONG : VIN_NOISE;
        len = 17;
        if (kind == VIN_SHORT) begin
            len = $urandom_range(1, 16);
        end else if (kind == VIN_NOISE) begin
            len = $urandom_range(1, 20);
        end
        for (int p = 0; p < len; p++) begin
            chars.push_back(kind == VIN_NOISE ? 8'($urandom_range(0, 255)) : pick_legal());
        end
        if (len == 17) begin
            seal_vin(chars);
        end
        case (kind)
            VIN_WRONG_CHECK: begin
                // any legal character at the check place, letters and lower-case x included
                chars[vcdv_pkg::CHECK_POS] = $urandom_range(0, 3) == 0 ? "x" : pick_legal();
            end
            VIN_BAD_CHAR: chars[$urandom_range(0, 16)] = pick_bad();
            VIN_LONG: begin
                repeat ($urandom_range(1, 7)) begin
                    chars.push_back($urandom_range(0, 3) == 0 ? pick_bad() : pick_legal());
                end
            end
            default: ;
        endcase
        send_vin(chars);
    endtask

    initial begin
        logic [7:0] chars[$];
        string      demo;
        tracker     = new();
        idle_cycles = 0;
        chars_sent  = 0;
        burst_left  = 1;
        rx_style    = RX_OPEN;
        rx_left     = 0;
        rx_tick     = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= '0;
        i_last_char <= 1'b0;
        i_ready     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a well-formed vin whose check is X, partly lower case
        demo = "1m8gDM9aXKP042788";
        for (int p = 0; p < demo.len(); p++) begin
            chars.push_back(demo[p]);
        end
        send_vin(chars);
        // one-character vins: byte extremes, excluded letter, digit, lower-case z
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char("q", 1'b1);
        send_char(vcdv_pkg::CHAR_NINE, 1'b1);
        send_char(vcdv_pkg::CHAR_LZ, 1'b1);
        drain_results();

        while (chars_sent < TARGET_CHARS) begin
            send_random_vin();
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vcdv_pkg.sv
rtl/vcdv_char_map.sv
rtl/vcdv_accum.sv
rtl/vin_check_digit_validator.sv
bench/vin_check_digit_validator_tb.sv
